[rtl/macv_pkg.sv]
package macv_pkg;

  localparam int HistDepth = 32;
  localparam int PriceW    = 24;
  localparam int FracW     = 8;
  localparam int WinW      = 6;
  localparam int SlotW     = $clog2(HistDepth);
  localparam int DaysW     = $clog2(HistDepth + 1);
  localparam int SumW      = 30;
  localparam int SqW       = 54;
  localparam int ProdW     = 2 * PriceW;
  localparam int CmpW      = SumW + DaysW + 1;
  localparam int VarW      = SqW + DaysW;
  localparam int DivW      = VarW + 2 * FracW;
  localparam int DivrW     = 2 * DaysW;
  localparam int CntW      = $clog2(DivW + 1);
  localparam int MDvdW     = SumW + FracW;
  localparam int RootInW   = 64;
  localparam int AvgW      = 32;
  localparam int VolW      = 31;
  localparam int RegW      = 32;
  localparam int AddrW     = 4;

  localparam logic [1:0] RegShort = 2'd0;
  localparam logic [1:0] RegLong  = 2'd1;
  localparam logic [1:0] RegVol   = 2'd2;

  localparam logic [WinW-1:0] RstShort = WinW'(5);
  localparam logic [WinW-1:0] RstLong  = WinW'(20);
  localparam logic [WinW-1:0] RstVol   = WinW'(5);

  typedef enum logic [1:0] {SIG_NONE, SIG_BUY, SIG_SELL, SIG_HOLD} sig_e;

  typedef enum logic [1:0] {DIV_SHORT, DIV_LONG, DIV_VOL} div_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SUM_GO, ST_SUM_RUN, ST_PREP,
    ST_DS_GO, ST_DS_RUN, ST_DL_GO, ST_DL_RUN,
    ST_DV_GO, ST_DV_RUN, ST_SQ_GO, ST_SQ_RUN, ST_DONE
  } state_e;

  typedef struct packed {
    logic     accept;
    logic     sum_start;
    logic     prep;
    logic     div_start;
    logic     div_store;
    div_sel_e div_sel;
    logic     sqrt_start;
    logic     result_load;
  } cmd_t;

  typedef struct packed {
    logic sum_done;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } stat_t;

  function automatic logic [DaysW-1:0] clamp_win(logic [WinW-1:0] w);
    logic [DaysW-1:0] r;
    if (w == '0) begin
      r = DaysW'(1);
    end else if (int'(w) > HistDepth) begin
      r = DaysW'(HistDepth);
    end else begin
      r = DaysW'(w);
    end
    return r;
  endfunction

endpackage

[rtl/macv_div.sv]
module macv_div
  import macv_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivW-1:0]  dividend_i,
  input  logic [DivrW-1:0] divisor_i,
  input  logic [CntW-1:0]  count_i,
  output logic             busy_o,
  output logic [DivW-1:0]  quot_o
);

  logic             busy_q;
  logic [CntW-1:0]  cnt_q;
  logic [DivrW-1:0] rem_q;
  logic [DivrW-1:0] dvr_q;
  logic [DivW-1:0]  dvd_q;
  logic [DivW-1:0]  quot_q;
  logic [DivrW:0]   trial;
  logic             fits;

  assign trial = {rem_q, dvd_q[DivW-1]};
  assign fits  = trial >= {1'b0, dvr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= count_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      dvr_q  <= divisor_i;
      dvd_q  <= dividend_i;
      quot_q <= '0;
    end else if (busy_q) begin
      dvd_q  <= {dvd_q[DivW-2:0], 1'b0};
      quot_q <= {quot_q[DivW-2:0], fits};
      if (fits) begin
        rem_q <= DivrW'(trial - {1'b0, dvr_q});
      end else begin
        rem_q <= trial[DivrW-1:0];
      end
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

[rtl/macv_isqrt.sv]
module macv_isqrt
  import macv_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [RootInW-1:0] value_i,
  output logic               busy_o,
  output logic [VolW-1:0]    root_o
);

  logic               busy_q;
  logic [RootInW-1:0] n_q;
  logic [RootInW-1:0] res_q;
  logic [RootInW-1:0] bit_q;
  logic [RootInW-1:0] trial;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && bit_q == RootInW'(1)) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= value_i;
      res_q <= '0;
      bit_q <= RootInW'(1) << (RootInW - 2);
    end else if (busy_q) begin
      if (n_q >= trial) begin
        n_q   <= n_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign busy_o = busy_q;
  assign root_o = (res_q > RootInW'({VolW{1'b1}})) ? {VolW{1'b1}} : res_q[VolW-1:0];

endmodule

[rtl/macv_dp.sv]
module macv_dp
  import macv_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output stat_t                    stat_o,
  input  logic [WinW-1:0]          short_win_i,
  input  logic [WinW-1:0]          long_win_i,
  input  logic [WinW-1:0]          vol_win_i,
  input  logic signed [PriceW-1:0] close_price_i,
  input  logic                     series_start_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic signed [AvgW-1:0]   short_avg_o,
  output logic                     short_valid_o,
  output logic signed [AvgW-1:0]   long_avg_o,
  output logic                     long_valid_o,
  output logic [VolW-1:0]          volatility_o,
  output logic                     vol_valid_o,
  output logic [1:0]               signal_o
);

  logic [PriceW-1:0]       mem [HistDepth];
  logic [SlotW-1:0]        slot_q;
  logic [DaysW-1:0]        days_q;
  logic [SlotW-1:0]        slot_base;
  logic [DaysW-1:0]        days_base;
  logic [DaysW-1:0]        ws, wl, wv;

  logic                    sweeping_q;
  logic [DaysW-1:0]        k_q;
  logic [SlotW-1:0]        rd_addr;
  logic [PriceW-1:0]       rd_q;
  logic                    s1_v_q, s2_v_q;
  logic [DaysW-1:0]        s1_k_q, s2_k_q;
  logic signed [PriceW-1:0] p2_q;
  logic [ProdW-1:0]        sq2_q;
  logic signed [ProdW-1:0] sq_full;
  logic signed [SumW-1:0]  p2_ext;

  logic signed [SumW-1:0]  ss_q, ls_q, vs_q;
  logic [SqW-1:0]          vsq_q;

  logic signed [CmpW-1:0]  a_q, b_q;
  logic [VarW-1:0]         wsq_q, magsq_q;
  logic [SumW-1:0]         vmag;
  logic [2*SumW-1:0]       vmag_sq;
  logic [VarW-1:0]         var_d;

  logic [SumW-1:0]         smag, lmag;
  logic [DivW-1:0]         dvd;
  logic [DivrW-1:0]        dvr;
  logic [CntW-1:0]         dcnt;
  logic                    div_busy;
  logic [DivW-1:0]         quot;
  logic [DivW-1:0]         qs_q, ql_q;
  logic                    sqrt_busy;
  logic [VolW-1:0]         root;

  logic                    sv, lv, vv;
  logic                    out_valid_q;
  logic [AvgW-1:0]         short_avg_q, long_avg_q;
  logic [VolW-1:0]         vol_q;
  logic                    sv_q, lv_q, vv_q;
  sig_e                    sig_q, sig_d;

  function automatic logic [AvgW-1:0] sat_mean(logic neg, logic [DivW-1:0] q);
    logic [AvgW-1:0] r;
    if (!neg) begin
      r = (q > DivW'({(AvgW-1){1'b1}})) ? {1'b0, {(AvgW-1){1'b1}}} : q[AvgW-1:0];
    end else begin
      r = (q > (DivW'(1) << (AvgW - 1))) ? {1'b1, {(AvgW-1){1'b0}}} : AvgW'(-q[AvgW-1:0]);
    end
    return r;
  endfunction

  assign ws = clamp_win(short_win_i);
  assign wl = clamp_win(long_win_i);
  assign wv = clamp_win(vol_win_i);

  assign slot_base = series_start_i ? '0 : slot_q;
  assign days_base = series_start_i ? '0 : days_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      days_q <= '0;
    end else if (cmd_i.accept) begin
      slot_q <= slot_base + SlotW'(1);
      days_q <= (int'(days_base) < HistDepth) ? days_base + DaysW'(1) : days_base;
    end
  end

  // ring of prices, read one entry per cycle during the sweep
  assign rd_addr = slot_q - SlotW'(1) - k_q[SlotW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mem[slot_base] <= close_price_i;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweeping_q <= 1'b0;
      k_q        <= '0;
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
    end else begin
      s1_v_q <= sweeping_q && (k_q < days_q);
      s2_v_q <= s1_v_q;
      if (cmd_i.sum_start) begin
        sweeping_q <= 1'b1;
        k_q        <= '0;
      end else if (sweeping_q) begin
        if (k_q < days_q) begin
          k_q <= k_q + DaysW'(1);
        end else begin
          sweeping_q <= 1'b0;
        end
      end
    end
  end

  assign sq_full = $signed(rd_q) * $signed(rd_q);
  assign p2_ext  = {{(SumW-PriceW){p2_q[PriceW-1]}}, p2_q};

  always_ff @(posedge clk_i) begin
    s1_k_q <= k_q;
    s2_k_q <= s1_k_q;
    p2_q   <= rd_q;
    sq2_q  <= sq_full;
    if (cmd_i.sum_start) begin
      ss_q  <= '0;
      ls_q  <= '0;
      vs_q  <= '0;
      vsq_q <= '0;
    end else if (s2_v_q) begin
      if (s2_k_q < ws) begin
        ss_q <= ss_q + p2_ext;
      end
      if (s2_k_q < wl) begin
        ls_q <= ls_q + p2_ext;
      end
      if (s2_k_q < wv) begin
        vs_q  <= vs_q + p2_ext;
        vsq_q <= vsq_q + SqW'(sq2_q);
      end
    end
  end

  assign vmag    = vs_q[SumW-1] ? SumW'(-vs_q) : SumW'(vs_q);
  assign smag    = ss_q[SumW-1] ? SumW'(-ss_q) : SumW'(ss_q);
  assign lmag    = ls_q[SumW-1] ? SumW'(-ls_q) : SumW'(ls_q);
  assign vmag_sq = vmag * vmag;
  assign var_d   = wsq_q - magsq_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      a_q     <= ss_q * $signed({1'b0, wl});
      b_q     <= ls_q * $signed({1'b0, ws});
      wsq_q   <= vsq_q * wv;
      magsq_q <= VarW'(vmag_sq);
    end
  end

  always_comb begin
    case (cmd_i.div_sel)
      DIV_SHORT: begin
        dvd  = {smag, {(DivW-SumW){1'b0}}};
        dvr  = DivrW'(ws);
        dcnt = CntW'(MDvdW);
      end
      DIV_LONG: begin
        dvd  = {lmag, {(DivW-SumW){1'b0}}};
        dvr  = DivrW'(wl);
        dcnt = CntW'(MDvdW);
      end
      default: begin
        dvd  = {var_d, {(2*FracW){1'b0}}};
        dvr  = DivrW'(wv) * DivrW'(wv);
        dcnt = CntW'(DivW);
      end
    endcase
  end

  macv_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvr),
    .count_i    (dcnt),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_store && cmd_i.div_sel == DIV_SHORT) begin
      qs_q <= quot;
    end
    if (cmd_i.div_store && cmd_i.div_sel == DIV_LONG) begin
      ql_q <= quot;
    end
  end

  macv_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .value_i (quot[RootInW-1:0]),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

  assign sv = days_q >= ws;
  assign lv = days_q >= wl;
  assign vv = days_q >= wv;

  always_comb begin
    sig_d = SIG_NONE;
    if (sv && lv) begin
      if (a_q > b_q) begin
        sig_d = SIG_BUY;
      end else if (a_q < b_q) begin
        sig_d = SIG_SELL;
      end else begin
        sig_d = SIG_HOLD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.result_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      short_avg_q <= sv ? sat_mean(ss_q[SumW-1], qs_q) : '0;
      long_avg_q  <= lv ? sat_mean(ls_q[SumW-1], ql_q) : '0;
      vol_q       <= vv ? root : '0;
      sv_q        <= sv;
      lv_q        <= lv;
      vv_q        <= vv;
      sig_q       <= sig_d;
    end
  end

  assign stat_o.sum_done  = !sweeping_q && !s1_v_q && !s2_v_q;
  assign stat_o.div_done  = !div_busy;
  assign stat_o.sqrt_done = !sqrt_busy;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign short_avg_o   = short_avg_q;
  assign short_valid_o = sv_q;
  assign long_avg_o    = long_avg_q;
  assign long_valid_o  = lv_q;
  assign volatility_o  = vol_q;
  assign vol_valid_o   = vv_q;
  assign signal_o      = sig_q;

endmodule

[rtl/macv_ctrl.sv]
module macv_ctrl
  import macv_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_SUM_GO;
        end
      end
      ST_SUM_GO: begin
        cmd_o.sum_start = 1'b1;
        state_d         = ST_SUM_RUN;
      end
      ST_SUM_RUN: begin
        if (stat_i.sum_done) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_DS_GO;
      end
      ST_DS_GO: begin
        cmd_o.div_sel   = DIV_SHORT;
        cmd_o.div_start = 1'b1;
        state_d         = ST_DS_RUN;
      end
      ST_DS_RUN: begin
        cmd_o.div_sel = DIV_SHORT;
        if (stat_i.div_done) begin
          cmd_o.div_store = 1'b1;
          state_d         = ST_DL_GO;
        end
      end
      ST_DL_GO: begin
        cmd_o.div_sel   = DIV_LONG;
        cmd_o.div_start = 1'b1;
        state_d         = ST_DL_RUN;
      end
      ST_DL_RUN: begin
        cmd_o.div_sel = DIV_LONG;
        if (stat_i.div_done) begin
          cmd_o.div_store = 1'b1;
          state_d         = ST_DV_GO;
        end
      end
      ST_DV_GO: begin
        cmd_o.div_sel   = DIV_VOL;
        cmd_o.div_start = 1'b1;
        state_d         = ST_DV_RUN;
      end
      ST_DV_RUN: begin
        cmd_o.div_sel = DIV_VOL;
        if (stat_i.div_done) begin
          state_d = ST_SQ_GO;
        end
      end
      ST_SQ_GO: begin
        cmd_o.div_sel    = DIV_VOL;
        cmd_o.sqrt_start = 1'b1;
        state_d          = ST_SQ_RUN;
      end
      ST_SQ_RUN: begin
        if (stat_i.sqrt_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.result_load = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/moving_average_crossover_volatility_unit.sv]
// Moving average crossover with rolling volatility.
// Input channel: in_valid_i / in_ready_o carries one daily close in signed
// cents and a series start flag; a set flag restarts the history with this day.
// Output channel: out_valid_o / out_ready_i carries short and long means,
// the population standard deviation (all cents with 8 fraction bits) with
// their window-full flags, and the crossover code (none, buy, sell, hold).
// The user must set windows over the APB port at 0x0, 0x4 and 0x8 while
// idle; the block itself does not enforce it. One item is worked at a time:
// a sweep over the ring memory (one ring read per cycle), then three passes
// of one shared bit-serial divider and a 32-step square root.
// in_ready_o is high only between items; a finished result sits in the
// output register, so the next transfer in is taken while it waits.
// A stalled receiver holds the result and, once the next item is worked,
// holds that item until the register frees.
// Reset empties the history, clears out_valid_o, loads windows 5, 20, 5.
module moving_average_crossover_volatility_unit
  import macv_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [AddrW-1:0]         paddr,
  input  logic [RegW-1:0]          pwdata,
  output logic [RegW-1:0]          prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [PriceW-1:0] close_price_i,
  input  logic                     series_start_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [AvgW-1:0]   short_avg_o,
  output logic                     short_valid_o,
  output logic signed [AvgW-1:0]   long_avg_o,
  output logic                     long_valid_o,
  output logic [VolW-1:0]          volatility_o,
  output logic                     vol_valid_o,
  output logic [1:0]               signal_o
);

  logic [WinW-1:0] short_win_q, long_win_q, vol_win_q;
  logic            wr_en;
  cmd_t            cmd;
  stat_t           stat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_win_q <= RstShort;
      long_win_q  <= RstLong;
      vol_win_q   <= RstVol;
    end else if (wr_en) begin
      case (paddr[3:2])
        RegShort: short_win_q <= pwdata[WinW-1:0];
        RegLong:  long_win_q  <= pwdata[WinW-1:0];
        RegVol:   vol_win_q   <= pwdata[WinW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegShort: prdata = RegW'(short_win_q);
      RegLong:  prdata = RegW'(long_win_q);
      RegVol:   prdata = RegW'(vol_win_q);
      default:  prdata = '0;
    endcase
  end

  macv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  macv_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .short_win_i    (short_win_q),
    .long_win_i     (long_win_q),
    .vol_win_i      (vol_win_q),
    .close_price_i  (close_price_i),
    .series_start_i (series_start_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .short_avg_o    (short_avg_o),
    .short_valid_o  (short_valid_o),
    .long_avg_o     (long_avg_o),
    .long_valid_o   (long_valid_o),
    .volatility_o   (volatility_o),
    .vol_valid_o    (vol_valid_o),
    .signal_o       (signal_o)
  );

endmodule

[rtl/macv_checker.sv]
module macv_checker
  import macv_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic signed [AvgW-1:0] short_avg_o,
  input logic                   short_valid_o,
  input logic                   long_valid_o,
  input logic [VolW-1:0]        volatility_o,
  input logic                   vol_valid_o,
  input logic [1:0]             signal_o
);

  // one item in flight: no second transfer in right after one
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken twice in a row");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !short_valid_o |-> short_avg_o == '0)
    else $error("short mean not zero before window full");

  a_vol_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !vol_valid_o |-> volatility_o == '0)
    else $error("volatility not zero before window full");

  a_sig_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (!short_valid_o || !long_valid_o) |-> signal_o == SIG_NONE)
    else $error("crossover given before both windows full");

endmodule

bind moving_average_crossover_volatility_unit macv_checker u_macv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .short_avg_o   (short_avg_o),
  .short_valid_o (short_valid_o),
  .long_valid_o  (long_valid_o),
  .volatility_o  (volatility_o),
  .vol_valid_o   (vol_valid_o),
  .signal_o      (signal_o)
);

[tb/moving_average_crossover_volatility_unit_tb.sv]
`timescale 1ns / 100ps

module moving_average_crossover_volatility_unit_tb;
  import macv_pkg::*;

  localparam int WatchLimit = 20000;
  localparam int SettleCycles = 300;

  typedef struct {
    logic signed [AvgW-1:0] short_avg;
    logic                   short_ok;
    logic signed [AvgW-1:0] long_avg;
    logic                   long_ok;
    logic [VolW-1:0]        vol;
    logic                   vol_ok;
    sig_e                   sig;
  } day_stats_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [RegW-1:0] pwdata = '0;
  logic [RegW-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [PriceW-1:0] close_price_i = '0;
  logic series_start_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [AvgW-1:0] short_avg_o, long_avg_o;
  logic short_valid_o, long_valid_o, vol_valid_o;
  logic [VolW-1:0] volatility_o;
  logic [1:0] signal_o;

  moving_average_crossover_volatility_unit u_top (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic signed [PriceW-1:0] price_ring [HistDepth];
  int unsigned ring_slot, day_count;
  logic [WinW-1:0] short_win, long_win, vol_win;
  day_stats_t stats_q [$];
  int unsigned mismatches;

  // sender burst control
  int unsigned burst_left;
  bit no_gaps;
  int hold_cycles;
  int unsigned rx_stall_pct, rx_phase, idle_cycles;
  longint walk_level;

  function automatic int unsigned eff_win(logic [WinW-1:0] w);
    if (w == 0) return 1;
    if (w > HistDepth) return HistDepth;
    return w;
  endfunction

  function automatic longint ring_price(int unsigned back);
    return longint'(price_ring[(ring_slot + HistDepth - 1 - back) % HistDepth]);
  endfunction

  function automatic longint window_total(int unsigned w);
    longint s;
    s = 0;
    for (int unsigned k = 0; k < w && k < day_count; k++) s += ring_price(k);
    return s;
  endfunction

  function automatic longint unsigned window_squares(int unsigned w);
    longint unsigned s;
    longint p;
    s = 0;
    for (int unsigned k = 0; k < w && k < day_count; k++) begin
      p = ring_price(k);
      if (p < 0) p = -p;
      s += longint'(p) * longint'(p);
    end
    return s;
  endfunction

  function automatic logic [AvgW-1:0] fixed_mean(longint sum, int unsigned w);
    longint q;
    q = (sum * 256) / longint'(w);
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[AvgW-1:0];
  endfunction

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [VolW-1:0] fixed_std(longint sum, longint unsigned sq,
                                                int unsigned w);
    longint unsigned mag, d, ww, q, r, v, s;
    mag = sum < 0 ? longint'(-sum) : longint'(sum);
    d = longint'(w) * sq - mag * mag;
    ww = longint'(w) * longint'(w);
    q = d / ww;
    r = d % ww;
    v = (q << (2 * FracW)) + ((r << (2 * FracW)) / ww);
    s = int_root(v);
    if (s > 64'h7FFFFFFF) s = 64'h7FFFFFFF;
    return s[VolW-1:0];
  endfunction

  function automatic day_stats_t predict_day(logic signed [PriceW-1:0] price, logic start);
    day_stats_t e;
    int unsigned ws, wl, wv;
    longint ssum, lsum, vsum, a, b;
    ws = eff_win(short_win);
    wl = eff_win(long_win);
    wv = eff_win(vol_win);
    if (start) begin
      ring_slot = 0;
      day_count = 0;
    end
    price_ring[ring_slot] = price;
    ring_slot = (ring_slot + 1) % HistDepth;
    if (day_count < HistDepth) day_count++;
    ssum = window_total(ws);
    lsum = window_total(wl);
    vsum = window_total(wv);
    e.short_ok = day_count >= ws;
    e.long_ok = day_count >= wl;
    e.vol_ok = day_count >= wv;
    e.sig = SIG_NONE;
    if (e.short_ok && e.long_ok) begin
      a = ssum * longint'(wl);
      b = lsum * longint'(ws);
      e.sig = a > b ? SIG_BUY : (a < b ? SIG_SELL : SIG_HOLD);
    end
    e.short_avg = e.short_ok ? fixed_mean(ssum, ws) : '0;
    e.long_avg = e.long_ok ? fixed_mean(lsum, wl) : '0;
    e.vol = e.vol_ok ? fixed_std(vsum, window_squares(wv), wv) : '0;
    return e;
  endfunction

  task automatic write_window(logic [1:0] idx, logic [WinW-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'(idx) << 2;
    pwdata <= RegW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegShort: short_win = val;
      RegLong:  long_win = val;
      default:  vol_win = val;
    endcase
  endtask

  task automatic set_windows(logic [WinW-1:0] s, logic [WinW-1:0] l, logic [WinW-1:0] v);
    write_window(RegShort, s);
    write_window(RegLong, l);
    write_window(RegVol, v);
  endtask

  task automatic send_day(logic signed [PriceW-1:0] price, logic start);
    int unsigned gap;
    day_stats_t exp_day;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap = $urandom_range(1, 15);
        @(posedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left--;
    end
    in_valid_i <= 1'b1;
    close_price_i <= price;
    series_start_i <= start;
    do @(posedge clk_i); while (!in_ready_o);
    exp_day = predict_day(price, start);
    stats_q.insert(stats_q.size(), exp_day);
  endtask

  task automatic wait_idle();
    @(posedge clk_i);
    in_valid_i <= 1'b0;
    while (stats_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic signed [PriceW-1:0] next_price();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      walk_level += $signed($urandom_range(0, 2000)) - 1000;
      if (walk_level > 8388607) walk_level = 8388607;
      if (walk_level < -8388608) walk_level = -8388608;
      return walk_level[PriceW-1:0];
    end else if (pick < 90) begin
      return PriceW'($urandom());
    end else if (pick < 95) begin
      return 24'sh7FFFFF;
    end
    return 24'sh800000;
  endfunction

  task automatic test_default_windows();
    for (int i = 0; i < 22; i++)
      send_day(i % 3 == 0 ? 24'sh7FFFFF : (i % 3 == 1 ? 24'sh800000 : 24'sd1), i == 0);
    wait_idle();
  endtask

  task automatic test_window_limits();
    set_windows(6'd0, 6'd63, 6'd40);
    send_day(24'sd100, 1'b1);
    send_day(-24'sd100, 1'b0);
    wait_idle();
    set_windows(6'd1, 6'd1, 6'd1);
    send_day(24'sd5, 1'b0);
    send_day(24'sd5, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_series();
    logic [WinW-1:0] w [3];
    int unsigned seg;
    for (int ph = 0; ph < 8; ph++) begin
      no_gaps = (ph % 3 == 2);
      for (int j = 0; j < 3; j++)
        w[j] = ($urandom_range(0, 9) == 0) ? WinW'($urandom()) : WinW'($urandom_range(1, 32));
      if (ph == 0) begin
        w[0] = 6'd32; w[1] = 6'd32; w[2] = 6'd32;
      end
      set_windows(w[0], w[1], w[2]);
      walk_level = $signed($urandom()) >>> 8;
      seg = 0;
      for (int i = 0; i < 110; i++) begin
        if (seg == 0) seg = $urandom_range(20, 80);
        seg--;
        send_day(next_price(), i == 0 || seg == 0 && $urandom_range(0, 3) == 0 ||
                 $urandom_range(0, 99) == 0);
      end
      wait_idle();
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_output_hold();
    set_windows(RstShort, RstLong, RstVol);
    no_gaps = 1'b1;
    hold_cycles = 1500;
    for (int i = 0; i < 60; i++) send_day(next_price(), i == 0);
    no_gaps = 1'b0;
    wait_idle();
  endtask

  // receiver with changing stall pattern and result compare
  always @(posedge clk_i) begin
    day_stats_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (stats_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer");
        end else begin
          e = stats_q.pop_front();
          if (short_avg_o !== e.short_avg || short_valid_o !== e.short_ok ||
              long_avg_o !== e.long_avg || long_valid_o !== e.long_ok ||
              volatility_o !== e.vol || vol_valid_o !== e.vol_ok || signal_o !== e.sig) begin
            mismatches++;
            if (mismatches <= 10)
              $display("exp %0d/%b %0d/%b %0d/%b %0d got %0d/%b %0d/%b %0d/%b %0d",
                       e.short_avg, e.short_ok, e.long_avg, e.long_ok, e.vol, e.vol_ok,
                       e.sig, short_avg_o, short_valid_o, long_avg_o, long_valid_o,
                       volatility_o, vol_valid_o, signal_o);
          end
        end
      end
      rx_phase++;
      if (rx_phase % 2000 == 0) rx_stall_pct = $urandom_range(0, 2) * 35;
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= $urandom_range(0, 99) >= rx_stall_pct;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > WatchLimit) begin
      $display("moving_average_crossover_volatility_unit: mismatch");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    burst_left = 0;
    no_gaps = 1'b0;
    hold_cycles = 0;
    rx_stall_pct = 0;
    rx_phase = 0;
    idle_cycles = 0;
    walk_level = 100000;
    ring_slot = 0;
    day_count = 0;
    short_win = RstShort;
    long_win = RstLong;
    vol_win = RstVol;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_default_windows();
    test_window_limits();
    test_random_series();
    test_output_hold();
    if (mismatches == 0) begin
      $display("moving_average_crossover_volatility_unit: match");
    end else begin
      $display("moving_average_crossover_volatility_unit: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/macv_pkg.sv
rtl/macv_div.sv
rtl/macv_isqrt.sv
rtl/macv_dp.sv
rtl/macv_ctrl.sv
rtl/moving_average_crossover_volatility_unit.sv
rtl/macv_checker.sv
tb/moving_average_crossover_volatility_unit_tb.sv
